// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the RTL. Define ASSERT_OFF to
// compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/t3ls_pkg.sv =====
// ----------------------------------------------------------------------------
// Top-three selector package
// Field widths, request and result types of the lexicographic selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package t3ls_pkg;

    localparam int TOP_COUNT_DEFAULT = 3;

    localparam int TAG_W    = 16;
    localparam int SCORE_W  = 16;
    localparam int RATING_W = 10;
    localparam int PRICE_W  = 24;
    localparam int RANK_W   = 2;

    // Sort key: score, then rating, then inverted price, so one unsigned
    // magnitude compare gives the whole ordering.
    localparam int KEY_W = SCORE_W + RATING_W + PRICE_W;

    typedef struct packed {
        logic [TAG_W-1:0]    item_tag;
        logic [SCORE_W-1:0]  item_score;
        logic [RATING_W-1:0] item_rating;
        logic [PRICE_W-1:0]  item_price;
        logic                last_item;
    } item_t;

    typedef struct packed {
        logic [RANK_W-1:0]   rank;
        logic [TAG_W-1:0]    best_tag;
        logic [SCORE_W-1:0]  best_score;
        logic [RATING_W-1:0] best_rating;
        logic [PRICE_W-1:0]  best_price;
        logic                final_rank;
    } result_t;

    // One held record.
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [SCORE_W-1:0]  score;
        logic [RATING_W-1:0] rating;
        logic [PRICE_W-1:0]  price;
    } rec_t;

endpackage

// ===== hdl/top3_lexicographic_selector.sv =====
// ----------------------------------------------------------------------------
// Top-three lexicographic selector
// Keeps the best TOP_COUNT records of a set and emits them in rank order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The block accepts one record request per clock cycle and keeps the best
// TOP_COUNT records seen since the last set ended, ranked by score (higher
// first), then rating in tenths (higher first), then price (lower first); on
// a full tie the earlier record stays above the later one. Each record is
// compared against all slots in parallel and inserted in the same cycle, so
// ordinary records never stall. When the record marked last_item is accepted
// it is inserted first, then the whole ranking is copied into an output
// queue and the slots are emptied, so the next set can start on the very
// next cycle. The queue emits one result per cycle unless result_stall is
// high, rank 1 first, with final_rank set on the last; a set yields
// between one and TOP_COUNT results. A further record marked last is
// stalled until the queue has fully drained, so the time to drain the held
// results, including any result_stall, bounds how often sets can end.
// Nothing needs clearing after reset, and the rank field is two bits wide,
// wrapping when TOP_COUNT exceeds three.
module top3_lexicographic_selector #(
    parameter int TOP_COUNT = t3ls_pkg::TOP_COUNT_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  t3ls_pkg::item_t   item_data,
    output logic              result_valid,
    input  logic              result_stall,
    output t3ls_pkg::result_t result_data
);

    // Ranking slots, slot 0 best. Valid slots always form a prefix.
    logic [TOP_COUNT-1:0] slot_valid_reg;
    logic [TOP_COUNT-1:0] slot_valid_next;
    t3ls_pkg::rec_t       slot_reg  [TOP_COUNT];
    t3ls_pkg::rec_t       slot_next [TOP_COUNT];

    // Output queue, a shift line read only at its head.
    logic [TOP_COUNT-1:0] snap_valid_reg;
    logic [TOP_COUNT-1:0] snap_valid_after;
    t3ls_pkg::rec_t       snap_reg  [TOP_COUNT];
    logic [t3ls_pkg::RANK_W-1:0] rank_reg;

    t3ls_pkg::rec_t       new_rec;
    logic [t3ls_pkg::KEY_W-1:0] new_key;
    logic [TOP_COUNT-1:0] hit;
    logic [TOP_COUNT-1:0] hit_above;
    logic                 item_acc;
    logic                 result_acc;

    assign item_acc   = item_valid && !item_stall;
    assign result_acc = result_valid && !result_stall;

    // Only a record that ends a set needs the output queue, and the queue
    // must be empty to take the new ranking.
    assign item_stall = result_valid && item_data.last_item;

    assign new_rec.tag    = item_data.item_tag;
    assign new_rec.score  = item_data.item_score;
    assign new_rec.rating = item_data.item_rating;
    assign new_rec.price  = item_data.item_price;
    assign new_key = {item_data.item_score, item_data.item_rating, ~item_data.item_price};

    // A slot is hit when it is empty or the new record ranks strictly above
    // it. Because the slots are sorted, the hit vector is a suffix: the
    // lowest hit slot receives the record and the ones below it move down.
    genvar k;
    generate
        for (k = 0; k < TOP_COUNT; k++)
        begin : g_slot
            logic [t3ls_pkg::KEY_W-1:0] slot_key;
            assign slot_key = {slot_reg[k].score, slot_reg[k].rating, ~slot_reg[k].price};
            assign hit[k]   = !slot_valid_reg[k] || (new_key > slot_key);

            if (k == 0)
            begin : g_top
                assign hit_above[k] = 1'b0;
                always_comb
                begin
                    slot_valid_next[k] = slot_valid_reg[k];
                    slot_next[k]       = slot_reg[k];
                    if (hit[k])
                    begin
                        slot_valid_next[k] = 1'b1;
                        slot_next[k]       = new_rec;
                    end
                end
            end
            else
            begin : g_lower
                assign hit_above[k] = hit[k-1];
                always_comb
                begin
                    slot_valid_next[k] = slot_valid_reg[k];
                    slot_next[k]       = slot_reg[k];
                    if (hit[k] && hit_above[k])
                    begin
                        slot_valid_next[k] = slot_valid_reg[k-1];
                        slot_next[k]       = slot_reg[k-1];
                    end
                    else if (hit[k])
                    begin
                        slot_valid_next[k] = 1'b1;
                        slot_next[k]       = new_rec;
                    end
                end
            end
        end
    endgenerate

    // Slot storage: the payload needs no reset, only the valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (item_acc)
        begin
            slot_valid_reg <= item_data.last_item ? '0 : slot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            for (int i = 0; i < TOP_COUNT; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    // Output queue: loaded whole at the end of a set, shifted by one on each
    // result taken.
    assign snap_valid_after = snap_valid_reg >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= '0;
            rank_reg       <= '0;
        end
        else if (item_acc && item_data.last_item)
        begin
            snap_valid_reg <= slot_valid_next;
            rank_reg       <= t3ls_pkg::RANK_W'(1);
        end
        else if (result_acc)
        begin
            snap_valid_reg <= snap_valid_after;
            rank_reg       <= rank_reg + t3ls_pkg::RANK_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc && item_data.last_item)
        begin
            for (int i = 0; i < TOP_COUNT; i++)
            begin
                snap_reg[i] <= slot_next[i];
            end
        end
        else if (result_acc)
        begin
            for (int i = 0; i < TOP_COUNT - 1; i++)
            begin
                snap_reg[i] <= snap_reg[i+1];
            end
        end
    end

    assign result_valid            = snap_valid_reg[0];
    assign result_data.rank        = rank_reg;
    assign result_data.best_tag    = snap_reg[0].tag;
    assign result_data.best_score  = snap_reg[0].score;
    assign result_data.best_rating = snap_reg[0].rating;
    assign result_data.best_price  = snap_reg[0].price;
    assign result_data.final_rank  = !snap_valid_after[0];

    // Held slots must always be a contiguous run from the best slot down.
    `ASSERT_IMPLY(a_slot_prefix, clk, rst_n, 1'b1,
        ((slot_valid_reg >> 1) & ~slot_valid_reg) == '0)
    // Ending a set empties the slots and puts at least one result out.
    `ASSERT_NEXT(a_set_end, clk, rst_n, item_acc && item_data.last_item,
        result_valid && (slot_valid_reg == '0))
    // A result not marked final is always followed by another one.
    `ASSERT_NEXT(a_run_continues, clk, rst_n, result_valid && !result_data.final_rank,
        result_valid)

endmodule
